FILE: src/gvcn_pkg.sv
`default_nettype none

package gvcn_pkg;

   localparam int MAX_ROWS_DEF  = 16;
   localparam int MAX_COLS_DEF  = 16;
   localparam int CELL_BITS_DEF = 8;
   localparam int POS_LIMIT     = 16;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_STEP    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] STATUS_MOVED   = 2'd0;
   localparam logic [1:0] STATUS_STUCK   = 2'd1;
   localparam logic [1:0] STATUS_ARRIVED = 2'd2;

   localparam logic [1:0] DIR_DOWN  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   localparam logic [2:0] CSR_DEST_ROW  = 3'd0;
   localparam logic [2:0] CSR_DEST_COL  = 3'd1;
   localparam logic [2:0] CSR_START_ROW = 3'd2;
   localparam logic [2:0] CSR_START_COL = 3'd3;
   localparam logic [2:0] CSR_ROWS_USED = 3'd4;
   localparam logic [2:0] CSR_COLS_USED = 3'd5;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        cell_row;
      logic [3:0]        cell_col;
      logic signed [7:0] cell_value;
   } gvcn_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] move_dir;
      logic [3:0] new_row;
      logic [3:0] new_col;
      logic       arrived;
   } gvcn_rsp_type;

   typedef struct packed {
      logic       clear;
      logic       en;
      logic [1:0] dir;
   } gvcn_best_ctl_type;

   typedef struct packed {
      logic       found;
      logic [1:0] dir;
      logic [2:0] obstacles;
   } gvcn_best_sts_type;

   typedef struct packed {
      logic [4:0] row;
      logic [4:0] col;
   } gvcn_pos_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_WRITE,
      ST_DONE
   } gvcn_state_type;

endpackage

`default_nettype wire

FILE: src/gvcn_map_ram.sv
`default_nettype none

module gvcn_map_ram #(
   parameter int DEPTH  = gvcn_pkg::MAX_ROWS_DEF * gvcn_pkg::MAX_COLS_DEF,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int WIDTH  = gvcn_pkg::CELL_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: src/gvcn_best_unit.sv
`default_nettype none

module gvcn_best_unit #(
   parameter int CELL_BITS = gvcn_pkg::CELL_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gvcn_pkg::gvcn_best_ctl_type    ctl,
   input  wire logic signed [CELL_BITS-1:0]    cand_value,
   input  wire logic                           cand_in_grid,
   output gvcn_pkg::gvcn_best_sts_type         sts
);

   localparam logic signed [CELL_BITS-1:0] ONE = CELL_BITS'(1);

   logic                        found_ff;
   logic [1:0]                  dir_ff;
   logic [2:0]                  obst_ff;
   logic signed [CELL_BITS-1:0] best_ff;
   logic                        free;
   logic                        take;

   assign free = cand_in_grid && (cand_value < ONE);
   assign take = free && (!found_ff || (cand_value > best_ff));

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff <= 1'b0;
         obst_ff  <= 3'd0;
      end else if (ctl.en) begin
         if (take) begin
            found_ff <= 1'b1;
         end
         if (!free) begin
            obst_ff <= obst_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en && take) begin
         best_ff <= cand_value;
         dir_ff  <= ctl.dir;
      end
   end

   assign sts.found     = found_ff;
   assign sts.dir       = dir_ff;
   assign sts.obstacles = obst_ff;

endmodule

`default_nettype wire

FILE: src/grid_visit_count_navigator.sv
// grid walker over a cell map held in one single-port-write memory
// req channel (valid/ready) carries write-cell, step and restart transactions;
// rsp channel (valid/ready) returns one transaction per step, none otherwise
// csr port: csr_we, csr_index and csr_wdata write the destination, start and
// grid size registers, taken at any edge, meant while the block is idle
// write and restart transactions leave the block idle and ready again
// a step makes one map memory read per cycle for the own cell and four
// neighbors through a registered read port, the neighbors judged one a
// cycle by a shared compare unit; then the WRITE state writes the own
// cell back and moves, and the DONE state loads the output register;
// no new transaction is taken until the step's result is loaded
// a step on the destination skips the map reads and goes to the DONE state
// after reset a clearing pass zeroes all MAX_ROWS*MAX_COLS map cells
// (256 at the defaults), with req_ready low; csr writes are taken meanwhile
// the result sits in an output register; while it stalls the block keeps
// taking write, restart and step transactions; a finished step waits for it
`default_nettype none

module grid_visit_count_navigator #(
   parameter int MAX_ROWS  = gvcn_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = gvcn_pkg::MAX_COLS_DEF,
   parameter int CELL_BITS = gvcn_pkg::CELL_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire gvcn_pkg::gvcn_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output gvcn_pkg::gvcn_rsp_type      rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [4:0]             csr_wdata
);

   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int ROWS_LIM = (MAX_ROWS < gvcn_pkg::POS_LIMIT) ? MAX_ROWS : gvcn_pkg::POS_LIMIT;
   localparam int COLS_LIM = (MAX_COLS < gvcn_pkg::POS_LIMIT) ? MAX_COLS : gvcn_pkg::POS_LIMIT;
   localparam int CELL_MAX_I = 2 ** (CELL_BITS - 1) - 1;
   localparam int CELL_MIN_I = -(2 ** (CELL_BITS - 1));
   localparam logic signed [16:0] CMAX17 = 17'(CELL_MAX_I);
   localparam logic signed [16:0] CMIN17 = 17'(CELL_MIN_I);
   localparam logic signed [CELL_BITS-1:0] CELL_MIN = CELL_BITS'(CELL_MIN_I);
   localparam logic signed [CELL_BITS-1:0] CELL_TWO = CELL_BITS'(2);
   localparam logic signed [CELL_BITS-1:0] CELL_ONE = CELL_BITS'(1);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [2:0] IDX_LAST = 3'd5;

   function automatic logic [4:0] eff_dim(input logic [4:0] used, input int lim);
      logic [4:0] d;
      d = (used == 5'd0) ? 5'd1 : used;
      if (int'(d) > lim) begin
         d = 5'(lim);
      end
      return d;
   endfunction

   function automatic gvcn_pkg::gvcn_pos_type nb_pos(input logic [3:0] r, input logic [3:0] c,
                                                     input logic [1:0] d);
      gvcn_pkg::gvcn_pos_type p;
      p.row = {1'b0, r};
      p.col = {1'b0, c};
      unique case (d)
         gvcn_pkg::DIR_DOWN:  p.row = p.row + 5'd1;
         gvcn_pkg::DIR_RIGHT: p.col = p.col + 5'd1;
         gvcn_pkg::DIR_LEFT:  p.col = p.col - 5'd1;
         gvcn_pkg::DIR_UP:    p.row = p.row - 5'd1;
         default:             p.row = p.row;
      endcase
      return p;
   endfunction

   gvcn_pkg::gvcn_state_type state_ff, state_in;

   logic [3:0] dest_row_ff, dest_col_ff, start_row_ff, start_col_ff;
   logic [4:0] rows_used_ff, cols_used_ff;
   logic [3:0] walker_row_ff, walker_col_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [2:0] idx_ff;
   logic rd_ok_ff, own_ok_ff;
   logic [ADDR_W-1:0] own_addr_ff;
   logic signed [CELL_BITS-1:0] own_val_ff;
   gvcn_pkg::gvcn_rsp_type res_ff, rsp_data_ff, step_res;
   logic rsp_valid_ff;

   logic [4:0] eff_rows, eff_cols;
   logic req_acc, at_dest;
   logic clr_we, write_own, load_rsp, issue_rd;
   gvcn_pkg::gvcn_best_ctl_type best_ctl;
   gvcn_pkg::gvcn_best_sts_type best_sts;
   gvcn_pkg::gvcn_pos_type rd_pos, mv_pos;
   logic rd_in_grid;
   logic [ADDR_W-1:0] rd_addr, wr_item_addr;
   logic wr_item_in_map;
   logic signed [16:0] wv_ext;
   logic signed [CELL_BITS-1:0] wv_sat, own_new;
   logic mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_BITS-1:0] mem_wdata, mem_rdata;
   logic [3:0] step_row, step_col;

   assign eff_rows = eff_dim(rows_used_ff, ROWS_LIM);
   assign eff_cols = eff_dim(cols_used_ff, COLS_LIM);
   assign req_acc  = req_valid && req_ready;
   assign at_dest  = (walker_row_ff == dest_row_ff) && (walker_col_ff == dest_col_ff);

   // read address: own cell first, then down, right, left, up
   always_comb begin
      if (idx_ff == 3'd0) begin
         rd_pos = nb_pos(walker_row_ff, walker_col_ff, gvcn_pkg::DIR_DOWN);
         rd_pos.row = {1'b0, walker_row_ff};
      end else begin
         rd_pos = nb_pos(walker_row_ff, walker_col_ff, 2'(idx_ff - 3'd1));
      end
   end

   assign rd_in_grid = (rd_pos.row < eff_rows) && (rd_pos.col < eff_cols);
   assign rd_addr    = ADDR_W'(int'(rd_pos.row) * MAX_COLS + int'(rd_pos.col));

   assign wr_item_in_map = (int'(req_data.cell_row) < MAX_ROWS) &&
                           (int'(req_data.cell_col) < MAX_COLS);
   assign wr_item_addr   = ADDR_W'(int'(req_data.cell_row) * MAX_COLS +
                                   int'(req_data.cell_col));

   always_comb begin
      wv_ext = 17'(req_data.cell_value);
      if (wv_ext > CMAX17) begin
         wv_ext = CMAX17;
      end else if (wv_ext < CMIN17) begin
         wv_ext = CMIN17;
      end
      wv_sat = CELL_BITS'(wv_ext);
   end

   always_comb begin
      if (best_sts.obstacles == 3'd3) begin
         own_new = CELL_TWO;
      end else if (own_val_ff != CELL_MIN) begin
         own_new = own_val_ff - CELL_ONE;
      end else begin
         own_new = own_val_ff;
      end
   end

   assign mv_pos   = nb_pos(walker_row_ff, walker_col_ff, best_sts.dir);
   assign step_row = best_sts.found ? mv_pos.row[3:0] : walker_row_ff;
   assign step_col = best_sts.found ? mv_pos.col[3:0] : walker_col_ff;

   always_comb begin
      step_res.status   = best_sts.found ? gvcn_pkg::STATUS_MOVED : gvcn_pkg::STATUS_STUCK;
      step_res.move_dir = best_sts.found ? best_sts.dir : gvcn_pkg::DIR_DOWN;
      step_res.new_row  = step_row;
      step_res.new_col  = step_col;
      step_res.arrived  = (step_row == dest_row_ff) && (step_col == dest_col_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gvcn_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = gvcn_pkg::ST_IDLE;
            end
         end
         gvcn_pkg::ST_IDLE: begin
            if (req_acc && (req_data.kind == gvcn_pkg::KIND_STEP)) begin
               state_in = at_dest ? gvcn_pkg::ST_DONE : gvcn_pkg::ST_RUN;
            end
         end
         gvcn_pkg::ST_RUN: begin
            if (idx_ff == IDX_LAST) begin
               state_in = gvcn_pkg::ST_WRITE;
            end
         end
         gvcn_pkg::ST_WRITE: begin
            state_in = gvcn_pkg::ST_DONE;
         end
         gvcn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = gvcn_pkg::ST_IDLE;
            end
         end
         default: state_in = gvcn_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready    = 1'b0;
      clr_we       = 1'b0;
      write_own    = 1'b0;
      load_rsp     = 1'b0;
      issue_rd     = 1'b0;
      best_ctl.clear = 1'b0;
      best_ctl.en    = 1'b0;
      best_ctl.dir   = 2'(idx_ff - 3'd2);
      unique case (state_ff)
         gvcn_pkg::ST_CLEAR: clr_we = 1'b1;
         gvcn_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            best_ctl.clear = 1'b1;
         end
         gvcn_pkg::ST_RUN: begin
            issue_rd    = (idx_ff < IDX_LAST);
            best_ctl.en = (idx_ff >= 3'd2);
         end
         gvcn_pkg::ST_WRITE: write_own = own_ok_ff;
         gvcn_pkg::ST_DONE:  load_rsp = !rsp_valid_ff || rsp_ready;
         default: clr_we = 1'b0;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      if (clr_we) begin
         mem_we = 1'b1;
      end else if (write_own) begin
         mem_we    = 1'b1;
         mem_waddr = own_addr_ff;
         mem_wdata = own_new;
      end else if (req_acc && (req_data.kind == gvcn_pkg::KIND_WRITE) && wr_item_in_map) begin
         mem_we    = 1'b1;
         mem_waddr = wr_item_addr;
         mem_wdata = wv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gvcn_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         idx_ff     <= 3'd0;
      end else begin
         state_ff <= state_in;
         if (clr_we) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (state_ff == gvcn_pkg::ST_RUN) begin
            idx_ff <= idx_ff + 3'd1;
         end else begin
            idx_ff <= 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_row_ff  <= 4'd9;
         dest_col_ff  <= 4'd9;
         start_row_ff <= 4'd0;
         start_col_ff <= 4'd0;
         rows_used_ff <= 5'd10;
         cols_used_ff <= 5'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            gvcn_pkg::CSR_DEST_ROW:  dest_row_ff  <= csr_wdata[3:0];
            gvcn_pkg::CSR_DEST_COL:  dest_col_ff  <= csr_wdata[3:0];
            gvcn_pkg::CSR_START_ROW: start_row_ff <= csr_wdata[3:0];
            gvcn_pkg::CSR_START_COL: start_col_ff <= csr_wdata[3:0];
            gvcn_pkg::CSR_ROWS_USED: rows_used_ff <= csr_wdata;
            gvcn_pkg::CSR_COLS_USED: cols_used_ff <= csr_wdata;
            default:                 dest_row_ff  <= dest_row_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walker_row_ff <= 4'd0;
         walker_col_ff <= 4'd0;
      end else if (req_acc && (req_data.kind == gvcn_pkg::KIND_RESTART)) begin
         walker_row_ff <= start_row_ff;
         walker_col_ff <= start_col_ff;
      end else if (state_ff == gvcn_pkg::ST_WRITE) begin
         walker_row_ff <= step_row;
         walker_col_ff <= step_col;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_rd) begin
         rd_ok_ff <= rd_in_grid;
      end
      if (issue_rd && (idx_ff == 3'd0)) begin
         own_ok_ff   <= rd_in_grid;
         own_addr_ff <= rd_addr;
      end
      if ((state_ff == gvcn_pkg::ST_RUN) && (idx_ff == 3'd1)) begin
         own_val_ff <= $signed(mem_rdata);
      end
      if (state_ff == gvcn_pkg::ST_WRITE) begin
         res_ff <= step_res;
      end else if (req_acc && (req_data.kind == gvcn_pkg::KIND_STEP) && at_dest) begin
         res_ff.status   <= gvcn_pkg::STATUS_ARRIVED;
         res_ff.move_dir <= gvcn_pkg::DIR_DOWN;
         res_ff.new_row  <= walker_row_ff;
         res_ff.new_col  <= walker_col_ff;
         res_ff.arrived  <= 1'b1;
      end
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gvcn_map_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .WIDTH  (CELL_BITS)
   ) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (rd_addr),
      .rdata (mem_rdata)
   );

   gvcn_best_unit #(
      .CELL_BITS (CELL_BITS)
   ) u_best (
      .clock        (clock),
      .reset        (reset),
      .ctl          (best_ctl),
      .cand_value   ($signed(mem_rdata)),
      .cand_in_grid (rd_ok_ff),
      .sts          (best_sts)
   );

endmodule

`default_nettype wire

FILE: verif/tb_grid_visit_count_navigator.sv
`default_nettype none

module tb_grid_visit_count_navigator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 12;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CELL_MIN       = -128;
   localparam int MAP_ROWS       = gvcn_pkg::MAX_ROWS_DEF;
   localparam int MAP_COLS       = gvcn_pkg::MAX_COLS_DEF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   gvcn_pkg::gvcn_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   gvcn_pkg::gvcn_rsp_type rsp_data;
   logic                   csr_we;
   logic [2:0]             csr_index;
   logic [4:0]             csr_wdata;

   // walker model
   logic signed [7:0] grid_cells [0:MAP_ROWS*MAP_COLS-1];
   logic [3:0] pos_row, pos_col;
   logic [3:0] goal_row, goal_col, home_row, home_col;
   logic [4:0] row_count, col_count;

   gvcn_pkg::gvcn_rsp_type expected_moves [$];
   int mismatch_count  = 0;
   int stall_count     = 0;
   int rsp_hold_cycles = 0;
   bit req_gaps_on     = 1'b1;
   bit rsp_gaps_on     = 1'b1;

   grid_visit_count_navigator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int used_extent(input logic [4:0] raw, input int limit);
      int span;
      span = (raw == 5'd0) ? 1 : int'(raw);
      if (span > limit) span = limit;
      if (span > gvcn_pkg::POS_LIMIT) span = gvcn_pkg::POS_LIMIT;
      return span;
   endfunction

   function automatic bit on_grid(input int r, input int c);
      return r >= 0 && c >= 0 && r < used_extent(row_count, MAP_ROWS) &&
             c < used_extent(col_count, MAP_COLS);
   endfunction

   function automatic int row_delta(input int d);
      case (2'(d))
         gvcn_pkg::DIR_DOWN: return 1;
         gvcn_pkg::DIR_UP:   return -1;
         default:            return 0;
      endcase
   endfunction

   function automatic int col_delta(input int d);
      case (2'(d))
         gvcn_pkg::DIR_RIGHT: return 1;
         gvcn_pkg::DIR_LEFT:  return -1;
         default:             return 0;
      endcase
   endfunction

   function automatic void predict_walk(input gvcn_pkg::gvcn_req_type t);
      int r, c, nr, nc, best, blocked, here;
      bit own;
      logic signed [7:0] around [4];
      gvcn_pkg::gvcn_rsp_type move;
      case (t.kind)
         gvcn_pkg::KIND_WRITE: grid_cells[int'(t.cell_row) * MAP_COLS + int'(t.cell_col)] =
            t.cell_value;
         gvcn_pkg::KIND_RESTART: begin
            pos_row = home_row;
            pos_col = home_col;
         end
         gvcn_pkg::KIND_STEP: begin
            if (pos_row == goal_row && pos_col == goal_col) begin
               move.status   = gvcn_pkg::STATUS_ARRIVED;
               move.move_dir = gvcn_pkg::DIR_DOWN;
               move.new_row  = pos_row;
               move.new_col  = pos_col;
               move.arrived  = 1'b1;
            end else begin
               r = int'(pos_row);
               c = int'(pos_col);
               here = r * MAP_COLS + c;
               own = on_grid(r, c);
               best = -1;
               blocked = 0;
               if (own && grid_cells[here] > CELL_MIN) grid_cells[here] -= 8'sd1;
               for (int d = int'(gvcn_pkg::DIR_DOWN); d <= int'(gvcn_pkg::DIR_UP); d++) begin
                  nr = r + row_delta(d);
                  nc = c + col_delta(d);
                  around[d] = on_grid(nr, nc) ? grid_cells[nr * MAP_COLS + nc] : 8'sd1;
                  if (around[d] < 1) begin
                     if (best < 0 || around[d] > around[best]) best = d;
                  end else begin
                     blocked++;
                  end
               end
               // dead end
               if (blocked == 3 && own) grid_cells[here] = 8'sd2;
               if (best < 0) begin
                  move.status   = gvcn_pkg::STATUS_STUCK;
                  move.move_dir = gvcn_pkg::DIR_DOWN;
                  move.arrived  = 1'b0;
               end else begin
                  pos_row = 4'(r + row_delta(best));
                  pos_col = 4'(c + col_delta(best));
                  move.status   = gvcn_pkg::STATUS_MOVED;
                  move.move_dir = 2'(best);
                  move.arrived  = (pos_row == goal_row && pos_col == goal_col);
               end
               move.new_row = pos_row;
               move.new_col = pos_col;
            end
            expected_moves.push_back(move);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_move(input gvcn_pkg::gvcn_rsp_type got);
      gvcn_pkg::gvcn_rsp_type want;
      if (expected_moves.size() == 0) begin
         $error("rsp transaction with none expected: %p", got);
         mismatch_count++;
      end else begin
         want = expected_moves.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.move_dir !== want.move_dir) begin
            $error("move_dir expected %0d actual %0d", want.move_dir, got.move_dir);
            mismatch_count++;
         end
         if (got.new_row !== want.new_row) begin
            $error("new_row expected %0d actual %0d", want.new_row, got.new_row);
            mismatch_count++;
         end
         if (got.new_col !== want.new_col) begin
            $error("new_col expected %0d actual %0d", want.new_col, got.new_col);
            mismatch_count++;
         end
         if (got.arrived !== want.arrived) begin
            $error("arrived expected %0d actual %0d", want.arrived, got.arrived);
            mismatch_count++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if ((rsp_valid && rsp_ready) === 1'b1) check_move(rsp_data);
      if ((req_valid && req_ready) === 1'b1) predict_walk(req_data);
      if ((req_valid && req_ready) === 1'b1 || (rsp_valid && rsp_ready) === 1'b1) begin
         stall_count = 0;
      end else begin
         stall_count++;
      end
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // result side: random stalls and one long hold-off on request
   initial begin
      int pause;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            pause = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end else begin
            pause = rsp_gaps_on ? $urandom_range(0, 6) : 0;
            if (pause > 0) begin
               rsp_ready <= 1'b0;
               repeat (pause) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1 && rsp_hold_cycles == 0) @(posedge clock);
      end
   end

   task automatic send_req(input logic [1:0] kind, input logic [3:0] row, col,
                           input logic signed [7:0] value);
      int gap;
      gvcn_pkg::gvcn_req_type item;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      item.kind       = kind;
      item.cell_row   = row;
      item.cell_col   = col;
      item.cell_value = value;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic step_walker();
      send_req(gvcn_pkg::KIND_STEP, 4'($urandom), 4'($urandom), 8'($urandom));
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [3:0] g_r, g_c, h_r, h_c,
                                input logic [4:0] rows, cols);
      logic [4:0] value;
      drain_block();
      for (int i = int'(gvcn_pkg::CSR_DEST_ROW); i <= int'(gvcn_pkg::CSR_COLS_USED); i++) begin
         case (3'(i))
            gvcn_pkg::CSR_DEST_ROW: begin
               value = {1'b0, g_r};
               goal_row = g_r;
            end
            gvcn_pkg::CSR_DEST_COL: begin
               value = {1'b0, g_c};
               goal_col = g_c;
            end
            gvcn_pkg::CSR_START_ROW: begin
               value = {1'b0, h_r};
               home_row = h_r;
            end
            gvcn_pkg::CSR_START_COL: begin
               value = {1'b0, h_c};
               home_col = h_c;
            end
            gvcn_pkg::CSR_ROWS_USED: begin
               value = rows;
               row_count = rows;
            end
            default: begin
               value = cols;
               col_count = cols;
            end
         endcase
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // reset settings, fresh map: tie order, dead ends, stuck, saturation
   task automatic test_reset_walk();
      step_walker();
      send_req(gvcn_pkg::KIND_WRITE, 4'd2, 4'd0, 8'sd5);
      send_req(gvcn_pkg::KIND_WRITE, 4'd1, 4'd1, 8'sd127);
      step_walker();
      step_walker();
      send_req(gvcn_pkg::KIND_WRITE, 4'd0, 4'd2, 8'sd1);
      step_walker();
      send_req(gvcn_pkg::KIND_WRITE, 4'd0, 4'd1, 8'h80);
      step_walker();
      send_req(KIND_UNUSED, 4'hf, 4'hf, 8'hff);
      send_req(gvcn_pkg::KIND_WRITE, 4'd15, 4'd15, 8'sd127);
   endtask

   // least visited neighbor wins, then reaching and standing on the goal
   task automatic test_choice_and_arrival();
      apply_setting(4'd5, 4'd6, 4'd4, 4'd5, 5'd10, 5'd10);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      send_req(gvcn_pkg::KIND_WRITE, 4'd5, 4'd5, -8'sd3);
      send_req(gvcn_pkg::KIND_WRITE, 4'd4, 4'd6, -8'sd1);
      send_req(gvcn_pkg::KIND_WRITE, 4'd4, 4'd4, -8'sd2);
      send_req(gvcn_pkg::KIND_WRITE, 4'd3, 4'd5, -8'sd5);
      step_walker();
      step_walker();
      step_walker();
   endtask

   // walker outside the used grid and out-of-range grid sizes
   task automatic test_off_grid_walker();
      apply_setting(4'd0, 4'd0, 4'd15, 4'd15, 5'd10, 5'd10);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      step_walker();
      apply_setting(4'd0, 4'd0, 4'd10, 4'd3, 5'd10, 5'd10);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      step_walker();
      apply_setting(4'd0, 4'd0, 4'd0, 4'd15, 5'd0, 5'd31);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      step_walker();
      apply_setting(4'd15, 4'd15, 4'd0, 4'd0, 5'd31, 5'd0);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      step_walker();
   endtask

   function automatic logic [4:0] pick_extent();
      case ($urandom_range(0, 9))
         0:       return 5'd0;
         1:       return 5'($urandom_range(16, 31));
         default: return 5'($urandom_range(1, 8));
      endcase
   endfunction

   // per phase: new settings, a partial maze, a restart, mostly steps
   task automatic test_random_mazes(input int phases);
      logic [4:0] rows, cols;
      logic [3:0] h_r, h_c;
      int span_r, span_c, pick;
      for (int p = 0; p < phases; p++) begin
         rows = pick_extent();
         cols = pick_extent();
         span_r = used_extent(rows, MAP_ROWS);
         span_c = used_extent(cols, MAP_COLS);
         if ($urandom_range(0, 9) == 0) begin
            h_r = 4'($urandom);
            h_c = 4'($urandom);
         end else begin
            h_r = 4'($urandom_range(0, span_r - 1));
            h_c = 4'($urandom_range(0, span_c - 1));
         end
         apply_setting(4'($urandom_range(0, span_r - 1)), 4'($urandom_range(0, span_c - 1)),
                       h_r, h_c, rows, cols);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(6, 14)) begin
            send_req(gvcn_pkg::KIND_WRITE, 4'($urandom_range(0, span_r - 1)),
                     4'($urandom_range(0, span_c - 1)),
                     ($urandom_range(0, 9) < 3) ? 8'($urandom_range(1, 127))
                                                : 8'($urandom_range(128, 256)));
         end
         send_req(gvcn_pkg::KIND_RESTART, 4'($urandom), 4'($urandom), 8'($urandom));
         repeat ($urandom_range(15, 35)) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               send_req(gvcn_pkg::KIND_WRITE, 4'($urandom), 4'($urandom), 8'($urandom));
            end else if (pick == 1) begin
               send_req(gvcn_pkg::KIND_RESTART, 4'($urandom), 4'($urandom), 8'($urandom));
            end else if (pick == 2) begin
               send_req(KIND_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom));
            end else begin
               step_walker();
            end
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // result side held off while steps keep coming, so req_ready must drop
   task automatic test_output_stall();
      apply_setting(4'd15, 4'd15, 4'd0, 4'd0, 5'd16, 5'd16);
      send_req(gvcn_pkg::KIND_RESTART, 4'd0, 4'd0, 8'sd0);
      req_gaps_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (30) step_walker();
      req_gaps_on = 1'b1;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= gvcn_pkg::CSR_DEST_ROW;
      csr_wdata <= '0;
      for (int i = 0; i < MAP_ROWS * MAP_COLS; i++) grid_cells[i] = '0;
      pos_row   = '0;
      pos_col   = '0;
      goal_row  = 4'd9;
      goal_col  = 4'd9;
      home_row  = '0;
      home_col  = '0;
      row_count = 5'd10;
      col_count = 5'd10;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_walk();
      test_choice_and_arrival();
      test_off_grid_walker();
      test_random_mazes(14);
      test_output_stall();
      drain_block();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
src/gvcn_pkg.sv
src/gvcn_map_ram.sv
src/gvcn_best_unit.sv
src/grid_visit_count_navigator.sv
verif/tb_grid_visit_count_navigator.sv
